// ===== hdl/multi_mode_saturation_waveshaper_macros.svh =====
// assertion macros shared by the waveshaper checker
`ifndef MULTI_MODE_SATURATION_WAVESHAPER_MACROS_SVH
`define MULTI_MODE_SATURATION_WAVESHAPER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MMSW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MMSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mmsw_pkg.sv =====
// constants and codes of the saturation waveshaper
`default_nettype none

package mmsw_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam int GAIN_W    = 16;
  localparam int MODE_W    = 2;
  localparam int CHAR_W    = 17;
  localparam int AMT_W     = 18;
  localparam int KW        = 19;
  localparam int PW        = 15;
  localparam int Q_SHIFT   = 14;
  localparam int CHAR_FRAC = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_GAIN  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHAPER_MODE = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHARACTER   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN = 8'd3;

  localparam logic [MODE_W-1:0] MODE_SOFT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIODE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ASYM  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MULTI = 2'd3;

  localparam logic [GAIN_W-1:0] DRIVE_GAIN_RST  = 16'd16384;
  localparam logic [MODE_W-1:0] SHAPER_MODE_RST = MODE_MULTI;
  localparam logic [CHAR_W-1:0] CHARACTER_RST   = 17'd0;
  localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RST = 16'd16384;

  localparam logic [GAIN_W-1:0] DRIVE_MAX     = 16'd32768;
  localparam logic [CHAR_W-1:0] CHAR_MAX      = 17'd65536;
  localparam logic [CHAR_W-1:0] CHAR_ASYM_MIN = 17'd19660;
  localparam logic [AMT_W-1:0]  AMT_BASE      = 18'd65536;

  // pre-tanh multipliers, Q.14
  localparam logic [KW-1:0] K_1P5   = 19'd24576;
  localparam logic [KW-1:0] K_DIODE = 19'd420103;
  localparam logic [KW-1:0] K_1P8   = 19'd29491;
  localparam logic [KW-1:0] K_1P2   = 19'd19661;

  // post-tanh multipliers, Q.14
  localparam logic [PW-1:0] P_ONE     = 15'd16384;
  localparam logic [PW-1:0] P_0P7     = 15'd11469;
  localparam logic [PW-1:0] P_0P9     = 15'd14746;
  localparam logic [PW-1:0] P_1P2     = 15'd19661;
  localparam logic [PW-1:0] P_INV_1P5 = 15'd10923;
  localparam logic [PW-1:0] P_INV_1P2 = 15'd13653;

endpackage

`default_nettype wire

// ===== hdl/mmsw_tanh.sv =====
// three-stage interpolated tanh lookup on a magnitude
`default_nettype none

module mmsw_tanh #(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int TANH_TABLE_BITS = 10,
  parameter int SIDE_W          = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [SAMPLE_WIDTH+2:0] in_arg,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  output logic [SAMPLE_WIDTH-1:0] out_val,
  output logic [SIDE_W-1:0]       out_side
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int TB   = TANH_TABLE_BITS;
  localparam int F    = SW - 1;
  localparam int AW   = SW + 3;
  localparam int SEG  = F + 3 - TB;
  localparam int LAST = 1 << TB;
  localparam int IW   = TB + 1;

  typedef logic [SW-1:0] rom_t [0:LAST];

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^(-2x) by recurrence, ratio from a taylor series
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    u    = 64'd1 << (36 - TB);
    term = 64'd1 << 32;
    r    = 64'd1 << 32;
    e    = 64'd1 << 32;
    for (int n = 1; n <= 20; n++) begin
      term = udiv((term * u) >> 32, 64'(n));
      if (n[0]) r = r - term;
      else      r = r + term;
    end
    for (int k = 0; k <= LAST; k++) begin
      num    = ((64'd1 << 32) - e) << F;
      den    = (64'd1 << 32) + e;
      rom[k] = SW'(udiv(num + (den >> 1), den));
      e      = (e * r + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

  localparam rom_t TANH_ROM = build_rom();

  logic [IW-1:0] seg_idx;
  logic [IW-1:0] idx_lo;
  logic [IW-1:0] idx_hi;
  logic          sat;

  logic              v1;
  logic [SW-1:0]     lo1;
  logic [SW-1:0]     hi1;
  logic [SEG-1:0]    f1;
  logic [SIDE_W-1:0] side1;

  logic [SW-1:0]     diff;
  logic [SW+SEG-1:0] prod;

  logic              v2;
  logic [SW-1:0]     base2;
  logic [SW-1:0]     inc2;
  logic [SIDE_W-1:0] side2;

  // arguments of 8.0 and above stick at the last entry
  always_comb begin
    seg_idx = in_arg[AW-1:SEG];
    sat     = seg_idx[TB];
    idx_lo  = sat ? IW'(LAST) : seg_idx;
    idx_hi  = sat ? IW'(LAST) : seg_idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo1   <= TANH_ROM[idx_lo];
      hi1   <= TANH_ROM[idx_hi];
      f1    <= in_arg[SEG-1:0];
      side1 <= in_side;
    end
  end

  always_comb begin
    diff = hi1 - lo1;
    prod = {{SEG{1'b0}}, diff} * {{SW{1'b0}}, f1};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base2 <= lo1;
      inc2  <= prod[SEG +: SW];
      side2 <= side1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val  <= base2 + inc2;
      out_side <= side2;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mmsw_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module mmsw_div #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int SIDE_W       = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [SAMPLE_WIDTH-1:0]  in_mag,
  input  logic [mmsw_pkg::AMT_W-1:0] divisor,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic [SAMPLE_WIDTH-1:0]  out_quo,
  output logic [SIDE_W-1:0]        out_side
);

  import mmsw_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int F  = SW - 1;
  localparam int RW = SW + CHAR_FRAC;
  localparam int CW = SW + AMT_W;

  logic [RW-1:0]     rem [0:F-1];
  logic [F-1:0]      quo [0:F-1];
  logic              vld [0:F-1];
  logic [SIDE_W-1:0] sd  [0:F-1];

  // quotient stays below 2^F since the divisor is at least 1.0
  for (genvar s = 0; s < F; s++) begin : g_stage
    localparam int J = F - 1 - s;
    logic [RW-1:0]     rem_in;
    logic [F-1:0]      quo_in;
    logic              v_in;
    logic [SIDE_W-1:0] s_in;
    logic [CW-1:0]     sub;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = {in_mag, {CHAR_FRAC{1'b0}}};
      assign quo_in = '0;
      assign v_in   = in_valid;
      assign s_in   = in_side;
    end else begin : g_rest
      assign rem_in = rem[s-1];
      assign quo_in = quo[s-1];
      assign v_in   = vld[s-1];
      assign s_in   = sd[s-1];
    end

    always_comb begin
      sub = CW'(divisor) << J;
      ge  = CW'(rem_in) >= sub;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[s] <= quo_in | (F'(ge) << J);
        sd[s]  <= s_in;
      end
    end

    if (s < F - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s] <= ge ? (rem_in - sub[RW-1:0]) : rem_in;
        end
      end
    end else begin : g_norem
      assign rem[s] = '0;
    end
  end

  assign out_valid = vld[F-1];
  assign out_quo   = {1'b0, quo[F-1]};
  assign out_side  = sd[F-1];

endmodule

`default_nettype wire

// ===== hdl/multi_mode_saturation_waveshaper.sv =====
// multi-mode tanh saturation waveshaper, top level
//
//   channel  | signals                                   | role
//   cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, always ready
//   in       | in_valid, in_ready, sample_in             | one sample word per transfer
//   out      | out_valid, out_ready, sample_out          | one shaped word per sample
//
// one sample per cycle sustained while out_ready holds; from accept to sample_out
// a sample passes three tanh lookups of three stages each and the divider
// that retires one quotient bit per stage
// reset clears valid bits and the config registers; the tanh table is a rom
// when sample_out waits with out_ready low the whole pipeline holds
`default_nettype none

module multi_mode_saturation_waveshaper #(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int TANH_TABLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mmsw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mmsw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out
);

  import mmsw_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int F  = SW - 1;
  localparam int XW = SW + 1;
  localparam int AW = SW + 3;
  localparam int SA_W = 1 + PW;
  localparam int SB_W = 1 + SW;
  localparam int SC_W = 1 + PW + SW;

  logic [GAIN_W-1:0] drive_gain;
  logic [MODE_W-1:0] shaper_mode;
  logic [CHAR_W-1:0] character_amount;
  logic [GAIN_W-1:0] output_gain;

  logic [GAIN_W-1:0] drv;
  logic [CHAR_W-1:0] chr;
  logic [AMT_W-1:0]  amt;
  logic              multi_strong;
  logic              en;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain       <= DRIVE_GAIN_RST;
      shaper_mode      <= SHAPER_MODE_RST;
      character_amount <= CHARACTER_RST;
      output_gain      <= OUTPUT_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DRIVE_GAIN:  drive_gain       <= cfg_data[GAIN_W-1:0];
        REG_SHAPER_MODE: shaper_mode      <= cfg_data[MODE_W-1:0];
        REG_CHARACTER:   character_amount <= cfg_data[CHAR_W-1:0];
        REG_OUTPUT_GAIN: output_gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    drv          = (drive_gain > DRIVE_MAX) ? DRIVE_MAX : drive_gain;
    chr          = (character_amount > CHAR_MAX) ? CHAR_MAX : character_amount;
    amt          = AMT_BASE + {chr, 1'b0};
    multi_strong = (shaper_mode == MODE_MULTI) && (chr > CHAR_ASYM_MIN);
  end

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // values run as sign and magnitude, the sign of the input word throughout
  logic          v1, sg1;
  logic [SW-1:0] m1;

  always_ff @(posedge clk) begin
    if (en) begin
      sg1 <= sample_in[SW-1];
      m1  <= sample_in[SW-1] ? (~sample_in + 1'b1) : sample_in;
    end
  end

  // drive gain
  logic [SW+GAIN_W-1:0] p2;
  logic                 v2, sg2;
  logic [XW-1:0]        x2;

  assign p2 = {{GAIN_W{1'b0}}, m1} * {{SW{1'b0}}, drv};

  always_ff @(posedge clk) begin
    if (en) begin
      sg2 <= sg1;
      x2  <= p2[Q_SHIFT +: XW];
    end
  end

  // first curve: pre-scale picked by mode and sign
  logic              pos2;
  logic [KW-1:0]     ka;
  logic [PW-1:0]     pa;
  logic [XW+KW-1:0]  p3;
  logic              v3, sg3;
  logic [AW-1:0]     a3;
  logic [PW-1:0]     pa3;

  always_comb begin
    pos2 = !sg2 && (x2 != '0);
    unique case (shaper_mode)
      MODE_SOFT: begin
        ka = K_1P5;
        pa = P_ONE;
      end
      MODE_DIODE: begin
        ka = K_DIODE;
        pa = P_0P7;
      end
      MODE_ASYM: begin
        ka = pos2 ? K_1P8 : K_1P2;
        pa = pos2 ? P_ONE : P_0P9;
      end
      MODE_MULTI: begin
        ka = K_1P5;
        pa = P_INV_1P5;
      end
    endcase
    p3 = {{KW{1'b0}}, x2} * {{XW{1'b0}}, ka};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg3 <= sg2;
      pa3 <= pa;
      a3  <= (|p3[XW+KW-1:Q_SHIFT+F+3]) ? (AW'(1) << (F + 3)) : p3[Q_SHIFT +: AW];
    end
  end

  logic              va;
  logic [SW-1:0]     ta;
  logic [SA_W-1:0]   side_a;

  mmsw_tanh #(
    .SAMPLE_WIDTH    (SW),
    .TANH_TABLE_BITS (TANH_TABLE_BITS),
    .SIDE_W          (SA_W)
  ) u_tanh_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_arg    (a3),
    .in_side   ({sg3, pa3}),
    .out_valid (va),
    .out_val   (ta),
    .out_side  (side_a)
  );

  logic [SW+PW-1:0] p4;
  logic             v4, sg4;
  logic [SW-1:0]    s4;

  assign p4 = {{PW{1'b0}}, ta} * {{SW{1'b0}}, side_a[PW-1:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      sg4 <= side_a[SA_W-1];
      s4  <= p4[Q_SHIFT +: SW];
    end
  end

  // multi-stage: tanh of A*s, then back down by A
  logic [SW+AMT_W-1:0] p5;
  logic                v5, sg5;
  logic [AW-1:0]       a5;
  logic [SW-1:0]       s5;

  assign p5 = {{AMT_W{1'b0}}, s4} * {{SW{1'b0}}, amt};

  always_ff @(posedge clk) begin
    if (en) begin
      sg5 <= sg4;
      s5  <= s4;
      a5  <= {1'b0, p5[CHAR_FRAC +: SW+2]};
    end
  end

  logic            vb;
  logic [SW-1:0]   tb;
  logic [SB_W-1:0] side_b;

  mmsw_tanh #(
    .SAMPLE_WIDTH    (SW),
    .TANH_TABLE_BITS (TANH_TABLE_BITS),
    .SIDE_W          (SB_W)
  ) u_tanh_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_arg    (a5),
    .in_side   ({sg5, s5}),
    .out_valid (vb),
    .out_val   (tb),
    .out_side  (side_b)
  );

  logic            vd;
  logic [SW-1:0]   qd;
  logic [SB_W-1:0] side_d;

  mmsw_div #(
    .SAMPLE_WIDTH (SW),
    .SIDE_W       (SB_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb),
    .in_mag    (tb),
    .divisor   (amt),
    .in_side   (side_b),
    .out_valid (vd),
    .out_quo   (qd),
    .out_side  (side_d)
  );

  logic          v6, sg6;
  logic [SW-1:0] s6;

  always_ff @(posedge clk) begin
    if (en) begin
      sg6 <= side_d[SB_W-1];
      s6  <= (shaper_mode == MODE_MULTI) ? qd : side_d[SW-1:0];
    end
  end

  // strong character: asymmetric stage on 1.2s
  logic [SW+PW-1:0] p7;
  logic             v7, sg7;
  logic [SW:0]      u7;
  logic [SW-1:0]    s7;

  assign p7 = {{PW{1'b0}}, s6} * {{SW{1'b0}}, P_1P2};

  always_ff @(posedge clk) begin
    if (en) begin
      sg7 <= sg6;
      s7  <= s6;
      u7  <= p7[Q_SHIFT +: SW+1];
    end
  end

  logic              pos7;
  logic [KW-1:0]     kc;
  logic [SW+KW:0]    p8;
  logic              v8, sg8;
  logic [AW-1:0]     a8;
  logic [PW-1:0]     pc8;
  logic [SW-1:0]     s8;

  always_comb begin
    pos7 = !sg7 && (u7 != '0);
    kc   = pos7 ? K_1P8 : K_1P2;
    p8   = {{KW{1'b0}}, u7} * {{(SW+1){1'b0}}, kc};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg8 <= sg7;
      s8  <= s7;
      pc8 <= pos7 ? P_ONE : P_0P9;
      a8  <= {1'b0, p8[Q_SHIFT +: SW+2]};
    end
  end

  logic            vc;
  logic [SW-1:0]   tc;
  logic [SC_W-1:0] side_c;

  mmsw_tanh #(
    .SAMPLE_WIDTH    (SW),
    .TANH_TABLE_BITS (TANH_TABLE_BITS),
    .SIDE_W          (SC_W)
  ) u_tanh_c (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .in_arg    (a8),
    .in_side   ({sg8, pc8, s8}),
    .out_valid (vc),
    .out_val   (tc),
    .out_side  (side_c)
  );

  logic [SW+PW-1:0] p9;
  logic             v9, sg9;
  logic [SW-1:0]    w9;
  logic [SW-1:0]    s9;

  assign p9 = {{PW{1'b0}}, tc} * {{SW{1'b0}}, side_c[SW +: PW]};

  always_ff @(posedge clk) begin
    if (en) begin
      sg9 <= side_c[SC_W-1];
      s9  <= side_c[SW-1:0];
      w9  <= p9[Q_SHIFT +: SW];
    end
  end

  logic [SW+PW-1:0] p10;
  logic             v10, sg10;
  logic [SW-1:0]    w10;
  logic [SW-1:0]    s10;

  assign p10 = {{PW{1'b0}}, w9} * {{SW{1'b0}}, P_INV_1P2};

  always_ff @(posedge clk) begin
    if (en) begin
      sg10 <= sg9;
      s10  <= s9;
      w10  <= p10[Q_SHIFT +: SW];
    end
  end

  // output gain
  logic [SW-1:0]        sel10;
  logic [SW+GAIN_W-1:0] p11;
  logic                 v11, sg11;
  logic [SW+1:0]        y11;

  always_comb begin
    sel10 = multi_strong ? w10 : s10;
    p11   = {{GAIN_W{1'b0}}, sel10} * {{SW{1'b0}}, output_gain};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg11 <= sg10;
      y11  <= p11[Q_SHIFT +: SW+2];
    end
  end

  // saturate to the signed sample range
  logic [SW+1:0] yneg;
  logic [SW+1:0] pos_lim;

  always_comb begin
    yneg    = ~y11 + 1'b1;
    pos_lim = (SW+2)'(1) << F;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sg11) begin
        sample_out <= (y11 > pos_lim) ? {1'b1, {F{1'b0}}} : yneg[SW-1:0];
      end else begin
        sample_out <= (y11 >= pos_lim) ? {1'b0, {F{1'b1}}} : y11[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      v9        <= 1'b0;
      v10       <= 1'b0;
      v11       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= va;
      v5        <= v4;
      v6        <= vd;
      v7        <= v6;
      v8        <= v7;
      v9        <= vc;
      v10       <= v9;
      v11       <= v10;
      out_valid <= v11;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mmsw_chk.sv =====
// port checker for the waveshaper, bound to the top level
`default_nettype none
`include "multi_mode_saturation_waveshaper_macros.svh"

module mmsw_chk #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] sample_out
);

  // a waiting word stays put
  `MMSW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sample_out), "sample_out changed while stalled")

  // input side moves exactly when the output register can
  `MMSW_ASSERT_NOW(a_in_ready, clk, rst, 1'b1, in_ready == (!out_valid || out_ready), "in_ready does not follow output stall")

  // register writes are never held off
  `MMSW_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "config write refused")

endmodule

bind multi_mode_saturation_waveshaper mmsw_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chk (.*);

`default_nettype wire
